// ----- hdl/rlp_pkg.sv -----
// Shared constants, codes and types for the RLP stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package rlp_pkg;

    localparam int MAX_DEPTH     = 8;
    localparam int MAX_LEN_BYTES = 4;

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int LCNT_W  = $clog2(MAX_LEN_BYTES + 1);

    // token events
    localparam logic [2:0] EV_SINGLE   = 3'd0;
    localparam logic [2:0] EV_STR_HDR  = 3'd1;
    localparam logic [2:0] EV_LIST_HDR = 3'd2;
    localparam logic [2:0] EV_LEN_BYTE = 3'd3;
    localparam logic [2:0] EV_PAYLOAD  = 3'd4;
    localparam logic [2:0] EV_ERROR    = 3'd5;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_DEEP    = 2'd1;
    localparam logic [1:0] ERR_WIDE    = 2'd2;
    localparam logic [1:0] ERR_OVERRUN = 2'd3;

    // parser states
    localparam logic [1:0] MODE_PREFIX  = 2'd0;
    localparam logic [1:0] MODE_LENGTH  = 2'd1;
    localparam logic [1:0] MODE_PAYLOAD = 2'd2;

    // prefix boundaries
    localparam logic [7:0] PFX_STR_SHORT  = 8'h80;
    localparam logic [7:0] PFX_STR_LONG   = 8'hb8;
    localparam logic [7:0] PFX_LIST_SHORT = 8'hc0;
    localparam logic [7:0] PFX_LIST_LONG  = 8'hf8;
    localparam logic [7:0] PFX_STR_BASE   = 8'hb7;
    localparam logic [7:0] PFX_LIST_BASE  = 8'hf7;

    // broadcast from the parser to every stack cell
    typedef struct packed {
        logic [31:0]        pos;
        logic               push;
        logic [31:0]        push_end;
        logic [DEPTH_W-1:0] depth;
    } t_cell_ctl;

    // handed from one cell to the cell below it
    typedef struct packed {
        logic               close;
        logic [DEPTH_W-1:0] closed;
        logic [31:0]        top_end;
    } t_cell_link;

endpackage
`default_nettype wire

// ----- hdl/rlp_if.sv -----
// Valid/ready channel interfaces for the byte input and the token output.
`timescale 1ns / 1ps
`default_nettype none
interface rlp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface rlp_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  value_byte;
    logic [31:0] item_length;
    logic [3:0]  depth;
    logic [3:0]  lists_closed;
    logic        top_item_done;
    logic [1:0]  error_code;

    modport source (output valid, output event_res, output value_byte, output item_length,
                    output depth, output lists_closed, output top_item_done,
                    output error_code, input ready);
    modport sink   (input valid, input event_res, input value_byte, input item_length,
                    input depth, input lists_closed, input top_item_done,
                    input error_code, output ready);
endinterface
`default_nettype wire

// ----- hdl/rlp_stack_cell.sv -----
// One level of the open-list stack: holds that list's end position and checks for closure.
`timescale 1ns / 1ps
`default_nettype none
module rlp_stack_cell
    import rlp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic [DEPTH_W-1:0] i_level,
    input  wire t_cell_ctl          i_ctl,
    input  wire t_cell_link         i_link,
    output t_cell_link              o_link
);

    logic [31:0] r_end;
    logic        occupied;
    logic        is_top;
    logic        hit;

    always_comb begin
        occupied = i_level < i_ctl.depth;
        is_top   = occupied && ((i_level + DEPTH_W'(1)) == i_ctl.depth);
        // a level closes only if every level above it closes on this word too
        hit      = occupied && (r_end == i_ctl.pos) && (is_top || i_link.close);

        o_link.close   = hit;
        o_link.closed  = i_link.closed + {{(DEPTH_W-1){1'b0}}, hit};
        o_link.top_end = i_link.top_end | (is_top ? r_end : 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && (i_level == i_ctl.depth)) begin
            r_end <= i_ctl.push_end;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/rlp_stream_decoder_unit.sv -----
// RLP stream decoder: one byte in, one token out, at one byte per clock unless the output stalls.
// Each accepted byte yields exactly one token in the output register; a new
// byte is taken every cycle the output is free or being drained, so throughput is one byte
// per clock. The per-byte path is the prefix decode, the room check against the innermost
// open list (one 32-bit subtract and compare) and the closure ripple through the row of
// stack cells, one cell per nesting level (MAX_DEPTH cells). Errors are sticky: after the
// first one every byte gives an error token with the latched code and the depth at the time
// of the error, until reset.
`timescale 1ns / 1ps
`default_nettype none
module rlp_stream_decoder_unit
    import rlp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rlp_byte_if.sink   i_byte,
    rlp_token_if.source o_tok
);

    // parser state
    logic [1:0]         r_mode,         n_mode;
    logic [LCNT_W-1:0]  r_len_left,     n_len_left;
    logic [31:0]        r_accum,        n_accum;
    logic               r_pend_list,    n_pend_list;
    logic [31:0]        r_payload_left, n_payload_left;
    logic [DEPTH_W-1:0] r_depth,        n_depth;
    logic [31:0]        r_pos,          n_pos;
    logic               r_err,          n_err;
    logic [1:0]         r_err_code,     n_err_code;

    // output register
    logic        r_out_valid;
    logic [2:0]  r_ev;
    logic [7:0]  r_val;
    logic [31:0] r_len;
    logic [3:0]  r_odepth;
    logic [3:0]  r_closed;
    logic        r_top;
    logic [1:0]  r_ecode;

    logic               accept;
    logic [7:0]         b;
    logic [31:0]        room;
    logic [31:0]        acc_new;
    logic [31:0]        pl_dec;
    logic               hdr;
    logic               hdr_list;
    logic [31:0]        hdr_len;
    logic               lng;
    logic               lng_list;
    logic [3:0]         nb;
    logic               push_req;
    logic [1:0]         err;
    logic [2:0]         ev;
    logic [DEPTH_W-1:0] closed;
    logic               top_done;
    logic [3:0]         out_depth;
    t_cell_ctl          ctl;
    t_cell_link         link [MAX_DEPTH:0];

    assign i_byte.ready = !r_out_valid || o_tok.ready;
    assign accept       = i_byte.valid && i_byte.ready;
    assign b            = i_byte.data_byte;

    // stack cells, highest level first in the closure ripple
    assign link[MAX_DEPTH] = '0;

    generate
        for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
            rlp_stack_cell u_cell (
                .i_clk  (i_clk),
                .i_level(DEPTH_W'(g)),
                .i_ctl  (ctl),
                .i_link (link[g+1]),
                .o_link (link[g])
            );
        end
    endgenerate

    always_comb begin
        n_mode         = r_mode;
        n_len_left     = r_len_left;
        n_accum        = r_accum;
        n_pend_list    = r_pend_list;
        n_payload_left = r_payload_left;
        n_depth        = r_depth;
        n_pos          = r_pos;
        n_err          = r_err;
        n_err_code     = r_err_code;

        room     = (r_depth == '0) ? 32'hffff_ffff : (link[0].top_end - r_pos);
        acc_new  = {r_accum[23:0], b};
        pl_dec   = r_payload_left - {31'd0, (r_payload_left != 32'd0)};
        hdr      = 1'b0;
        hdr_list = 1'b0;
        hdr_len  = 32'd0;
        lng      = 1'b0;
        lng_list = 1'b0;
        nb       = 4'd0;
        push_req = 1'b0;
        err      = ERR_NONE;
        ev       = EV_SINGLE;
        closed   = '0;
        top_done = 1'b0;

        case (r_mode)
            MODE_LENGTH: begin
                if (r_accum[31:24] != 8'd0) begin
                    err = ERR_WIDE;
                end else begin
                    n_accum = acc_new;
                    if (r_len_left <= LCNT_W'(1)) begin
                        n_len_left = '0;
                        ev         = r_pend_list ? EV_LIST_HDR : EV_STR_HDR;
                        hdr        = 1'b1;
                        hdr_list   = r_pend_list;
                        hdr_len    = acc_new;
                    end else begin
                        n_len_left = r_len_left - LCNT_W'(1);
                        ev         = EV_LEN_BYTE;
                    end
                end
            end
            MODE_PAYLOAD: begin
                ev             = EV_PAYLOAD;
                n_payload_left = pl_dec;
                if (pl_dec == 32'd0) begin
                    n_mode = MODE_PREFIX;
                end
            end
            default: begin
                n_mode = MODE_PREFIX;
                if (b < PFX_STR_SHORT) begin
                    ev = EV_SINGLE;
                end else if (b < PFX_STR_LONG) begin
                    ev      = EV_STR_HDR;
                    hdr     = 1'b1;
                    hdr_len = 32'(b - PFX_STR_SHORT);
                end else if (b < PFX_LIST_SHORT) begin
                    ev  = EV_LEN_BYTE;
                    lng = 1'b1;
                    nb  = 4'(b - PFX_STR_BASE);
                end else if (b < PFX_LIST_LONG) begin
                    ev       = EV_LIST_HDR;
                    hdr      = 1'b1;
                    hdr_list = 1'b1;
                    hdr_len  = 32'(b - PFX_LIST_SHORT);
                end else begin
                    ev       = EV_LEN_BYTE;
                    lng      = 1'b1;
                    lng_list = 1'b1;
                    nb       = 4'(b - PFX_LIST_BASE);
                end
            end
        endcase

        if (hdr) begin
            if (hdr_len > room) begin
                err = ERR_OVERRUN;
            end else if (hdr_list) begin
                if (hdr_len != 32'd0) begin
                    if (r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                        err = ERR_DEEP;
                    end else begin
                        push_req = 1'b1;
                    end
                end
                n_mode = MODE_PREFIX;
            end else if (hdr_len != 32'd0) begin
                n_mode         = MODE_PAYLOAD;
                n_payload_left = hdr_len;
            end else begin
                n_mode = MODE_PREFIX;
            end
        end

        if (lng) begin
            if (nb > 4'(MAX_LEN_BYTES)) begin
                err = ERR_WIDE;
            end else if ({28'd0, nb} > room) begin
                err = ERR_OVERRUN;
            end else begin
                n_mode      = MODE_LENGTH;
                n_len_left  = LCNT_W'(nb);
                n_accum     = 32'd0;
                n_pend_list = lng_list;
            end
        end

        if (err != ERR_NONE) begin
            n_err      = 1'b1;
            n_err_code = err;
        end else begin
            n_pos = r_pos + 32'd1;
            // a freshly opened list ends past this word, so nothing closes with a push
            if (push_req) begin
                n_depth = r_depth + DEPTH_W'(1);
            end else begin
                closed  = link[0].closed;
                n_depth = r_depth - link[0].closed;
            end
            top_done = (n_mode == MODE_PREFIX) && (n_depth == '0);
        end

        out_depth = 4'(n_depth);

        ctl.pos      = r_pos;
        ctl.push     = accept && !r_err && push_req && (err == ERR_NONE);
        ctl.push_end = r_pos + hdr_len;
        ctl.depth    = r_depth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_PREFIX;
            r_len_left     <= '0;
            r_accum        <= 32'd0;
            r_pend_list    <= 1'b0;
            r_payload_left <= 32'd0;
            r_depth        <= '0;
            r_pos          <= 32'd0;
            r_err          <= 1'b0;
            r_err_code     <= ERR_NONE;
            r_out_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                if (!r_err) begin
                    r_mode         <= n_mode;
                    r_len_left     <= n_len_left;
                    r_accum        <= n_accum;
                    r_pend_list    <= n_pend_list;
                    r_payload_left <= n_payload_left;
                    r_depth        <= n_depth;
                    r_pos          <= n_pos;
                    r_err          <= n_err;
                    r_err_code     <= n_err_code;
                end
            end else if (o_tok.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // token payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val <= b;
            if (r_err) begin
                r_ev     <= EV_ERROR;
                r_len    <= 32'd0;
                r_odepth <= 4'(r_depth);
                r_closed <= 4'd0;
                r_top    <= 1'b0;
                r_ecode  <= r_err_code;
            end else if (err != ERR_NONE) begin
                r_ev     <= EV_ERROR;
                r_len    <= 32'd0;
                r_odepth <= 4'(r_depth);
                r_closed <= 4'd0;
                r_top    <= 1'b0;
                r_ecode  <= err;
            end else begin
                r_ev     <= ev;
                r_len    <= hdr ? hdr_len : 32'd0;
                r_odepth <= out_depth;
                r_closed <= 4'(closed);
                r_top    <= top_done;
                r_ecode  <= ERR_NONE;
            end
        end
    end

    assign o_tok.valid         = r_out_valid;
    assign o_tok.event_res     = r_ev;
    assign o_tok.value_byte    = r_val;
    assign o_tok.item_length   = r_len;
    assign o_tok.depth         = r_odepth;
    assign o_tok.lists_closed  = r_closed;
    assign o_tok.top_item_done = r_top;
    assign o_tok.error_code    = r_ecode;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(MAX_DEPTH))
        else $error("open list count beyond stack size");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("latched error cleared without reset");

    a_err_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> $stable(r_pos) && $stable(r_depth) && $stable(r_err_code))
        else $error("parser state moved after an error");

    a_err_token_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_ev == EV_ERROR)) |-> (r_ecode != ERR_NONE))
        else $error("error token without an error code");

    // outside an error, the length state always has length bytes left to read
    a_len_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_err && (r_mode == MODE_LENGTH)) |-> (r_len_left != '0))
        else $error("length state with no length bytes left");

endmodule
`default_nettype wire
